// ----- rtl/arpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types, widths and codes of the address-resolution cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // field widths
    localparam int OP_W     = 1;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;

    // queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // op codes on the request channel
    localparam logic [OP_W-1:0] OP_LOOKUP = 1'b0;
    localparam logic [OP_W-1:0] OP_LEARN  = 1'b1;

    // status codes on the response channel
    localparam logic [STATUS_W-1:0] STS_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] STS_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_UPDATED  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;

    typedef enum logic
    {
        CMD_LOOKUP,
        CMD_LEARN
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t              kind;
        logic [IP_W-1:0]        ip_addr;
        logic [MAC_W-1:0]       mac_in;
    } cmd_t;

    typedef struct packed
    {
        logic                   valid;
        cmd_t                   cmd;
    } q_head_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_RESOLVE,
        BK_READ
    } bk_state_t;

endpackage

// ----- rtl/arpc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_req_if
// Request channel: lookup or learn items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface arpc_req_if;
    logic                           valid;
    logic                           ready;
    logic [arpc_pkg::OP_W-1:0]      op;
    logic [arpc_pkg::IP_W-1:0]      ip_addr;
    logic [arpc_pkg::MAC_W-1:0]     mac_in;

    modport source (output valid, output op, output ip_addr, output mac_in, input ready);
    modport sink   (input valid, input op, input ip_addr, input mac_in, output ready);
endinterface

// ----- rtl/arpc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface arpc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [arpc_pkg::STATUS_W-1:0]  status;
    logic [arpc_pkg::MAC_W-1:0]     mac_out;
    logic [arpc_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, output status, output mac_out, output slot, input ready);
    modport sink   (input valid, input status, input mac_out, input slot, output ready);
endinterface

// ----- rtl/arp_cache_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_table_core
// Fully associative IPv4-to-MAC resolution table with lookup and learn.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid / ready | op (1), ip_addr (32), mac_in (48)
//  rsp     | out | valid / ready | status (3), mac_out (48), slot (6)
//
//  Each item passes the back end as idle (compare and pop), then resolve
//  and write; a lookup that hits adds a read state for the registered
//  read of the MAC RAM. The address-cell compare and resolve sequence sets
//  the rate, one item at a time.
//  Reset clears the fill count, the queue and the output register; the
//  address cells and MAC RAM are never cleared, only filled cells are read.
//  A two-entry queue lets req keep flowing while a result waits on rsp.
//
module arp_cache_table_core (
    input  logic       clk,
    input  logic       rst_n,
    arpc_req_if.sink   req,
    arpc_rsp_if.source rsp
);

    // queue head and pop between the front and back ends
    arpc_pkg::q_head_t head;
    logic              pop;

    // front: accept, classify and queue items
    arpc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (pop),
        .head  (head)
    );

    // back: match, update the table and drive results
    arpc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

// ----- rtl/arpc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/arpc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_front
// Accept request items, classify them and hold them in a short queue.
// ----------------------------------------------------------------------------
module arpc_front (
    input  logic              clk,
    input  logic              rst_n,
    arpc_req_if.sink          req,
    input  logic              pop,
    output arpc_pkg::q_head_t head
);

    arpc_pkg::cmd_t                   q_item_reg [arpc_pkg::QDEPTH];
    logic [arpc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [arpc_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [arpc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [arpc_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [arpc_pkg::QCNT_W-1:0]      q_count_reg;
    logic [arpc_pkg::QCNT_W-1:0]      q_count_next;
    arpc_pkg::cmd_t                   cmd_in;
    logic                             push;

    // classify the incoming item
    always_comb
    begin
        cmd_in.kind    = (req.op == arpc_pkg::OP_LEARN) ? arpc_pkg::CMD_LEARN
                                                         : arpc_pkg::CMD_LOOKUP;
        cmd_in.ip_addr = req.ip_addr;
        cmd_in.mac_in  = req.mac_in;
    end

    assign req.ready = (q_count_reg != arpc_pkg::QCNT_W'(arpc_pkg::QDEPTH));
    assign push      = req.valid && req.ready;

    assign head.valid = (q_count_reg != '0);
    assign head.cmd   = q_item_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        q_count_next = q_count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == arpc_pkg::QPTR_W'(arpc_pkg::QDEPTH - 1))
                        ? '0 : arpc_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == arpc_pkg::QPTR_W'(arpc_pkg::QDEPTH - 1))
                        ? '0 : arpc_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        case ({push, pop})
            2'b10:   q_count_next = arpc_pkg::QCNT_W'(q_count_reg + 1'b1);
            2'b01:   q_count_next = arpc_pkg::QCNT_W'(q_count_reg - 1'b1);
            default: q_count_next = q_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_item_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- rtl/arpc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_back
// Match against the address cells, update the tables and deliver results.
// ----------------------------------------------------------------------------
module arpc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  arpc_pkg::q_head_t head,
    output logic              pop,
    arpc_rsp_if.source        rsp
);

    localparam int N = arpc_pkg::TABLE_ENTRIES;

    arpc_pkg::bk_state_t              state_reg;
    arpc_pkg::bk_state_t              state_next;

    logic [arpc_pkg::IP_W-1:0]        ip_cell_reg [N];
    logic [arpc_pkg::CNT_W-1:0]       count_reg;
    logic [arpc_pkg::CNT_W-1:0]       count_next;
    logic [N-1:0]                     match_reg;
    logic [N-1:0]                     match_next;
    arpc_pkg::cmd_t                   cur_reg;
    logic [arpc_pkg::IDX_W-1:0]       slot_reg;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [arpc_pkg::STATUS_W-1:0]    out_status_reg;
    logic [arpc_pkg::STATUS_W-1:0]    out_status_next;
    logic [arpc_pkg::MAC_W-1:0]       out_mac_reg;
    logic [arpc_pkg::MAC_W-1:0]       out_mac_next;
    logic [arpc_pkg::SLOT_W-1:0]      out_slot_reg;
    logic [arpc_pkg::SLOT_W-1:0]      out_slot_next;
    logic                             out_load;

    logic [arpc_pkg::IDX_W-1:0]       hit_idx;
    logic                             hit;
    logic                             out_free;
    logic                             has_room;
    logic [arpc_pkg::IDX_W-1:0]       free_idx;
    logic                             ip_we;

    logic                             ram_we;
    logic [arpc_pkg::IDX_W-1:0]       ram_waddr;
    logic                             ram_re;
    logic [arpc_pkg::MAC_W-1:0]       ram_rdata;

    // compare the queue head against every filled cell
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            match_next[k] = (ip_cell_reg[k] == head.cmd.ip_addr)
                         && (arpc_pkg::CNT_W'(k) < count_reg);
        end
    end

    // lowest matching cell wins
    always_comb
    begin
        hit_idx = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                hit_idx = arpc_pkg::IDX_W'(k);
            end
        end
    end

    assign hit      = |match_reg;
    assign out_free = !out_valid_reg || rsp.ready;
    assign has_room = (count_reg < arpc_pkg::CNT_W'(N));
    assign free_idx = count_reg[arpc_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pop             = 1'b0;
        ip_we           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx;
        ram_re          = 1'b0;
        out_load        = 1'b0;
        out_status_next = arpc_pkg::STS_MISS;
        out_mac_next    = '0;
        out_slot_next   = '0;

        case (state_reg)
            arpc_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    state_next = arpc_pkg::BK_RESOLVE;
                end
            end

            arpc_pkg::BK_RESOLVE:
            begin
                if (cur_reg.kind == arpc_pkg::CMD_LOOKUP && hit)
                begin
                    ram_re     = 1'b1;
                    state_next = arpc_pkg::BK_READ;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = arpc_pkg::BK_IDLE;
                    if (cur_reg.kind == arpc_pkg::CMD_LOOKUP)
                    begin
                        out_status_next = arpc_pkg::STS_MISS;
                    end
                    else if (hit)
                    begin
                        ram_we          = 1'b1;
                        out_status_next = arpc_pkg::STS_UPDATED;
                        out_slot_next   = arpc_pkg::SLOT_W'(hit_idx);
                    end
                    else if (has_room)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = free_idx;
                        ip_we           = 1'b1;
                        count_next      = arpc_pkg::CNT_W'(count_reg + 1'b1);
                        out_status_next = arpc_pkg::STS_INSERTED;
                        out_slot_next   = arpc_pkg::SLOT_W'(free_idx);
                    end
                    else
                    begin
                        out_status_next = arpc_pkg::STS_FULL;
                    end
                end
            end

            arpc_pkg::BK_READ:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = arpc_pkg::STS_HIT;
                    out_mac_next    = ram_rdata;
                    out_slot_next   = arpc_pkg::SLOT_W'(slot_reg);
                    state_next      = arpc_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = arpc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arpc_pkg::BK_IDLE;
            count_reg     <= '0;
            match_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                match_reg <= match_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head.cmd;
        end
        if (ram_re)
        begin
            slot_reg <= hit_idx;
        end
        if (ip_we)
        begin
            ip_cell_reg[free_idx] <= cur_reg.ip_addr;
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_mac_reg    <= out_mac_next;
            out_slot_reg   <= out_slot_next;
        end
    end

    arpc_ram #(
        .WIDTH (arpc_pkg::MAC_W),
        .DEPTH (N)
    ) u_mac_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cur_reg.mac_in),
        .re    (ram_re),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.mac_out = out_mac_reg;
    assign rsp.slot    = out_slot_reg;

`ifndef SYNTH
    // fill count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= arpc_pkg::CNT_W'(N))
        else $error("entry count exceeds table size");

    // learn never duplicates an address, so at most one cell matches
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == arpc_pkg::BK_RESOLVE |-> $onehot0(match_reg))
        else $error("more than one cell matches");

    // the table grows only together with an inserted result
    a_count_insert: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            out_valid_reg && out_status_reg == arpc_pkg::STS_INSERTED)
        else $error("entry count changed without insert");
`endif

endmodule

// ----- tb/arp_cache_table_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_table_core_test
// Self-checking bench for the IPv4-to-MAC resolution table. Lookup and learn
// items go in on req, results are checked on rsp against a local table model.
// ----------------------------------------------------------------------------
module arp_cache_table_core_test;

    localparam int CLK_HALF    = 6;
    localparam int RESET_TICKS = 11;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_TICKS = 16;

    // one expected result item on rsp
    typedef struct
    {
        logic [arpc_pkg::STATUS_W-1:0] status;
        logic [arpc_pkg::MAC_W-1:0]    mac_out;
        logic [arpc_pkg::SLOT_W-1:0]   slot;
    } arp_result_t;

    logic clk;
    logic rst_n;

    arpc_req_if req_bus();
    arpc_rsp_if rsp_bus();

    arp_cache_table_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Local copy of the table. Only slots below fill_count are ever read.
    logic [arpc_pkg::IP_W-1:0]  ip_table  [arpc_pkg::TABLE_ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] mac_table [arpc_pkg::TABLE_ENTRIES];
    int                         fill_count;

    // Results still owed by the block, oldest first.
    arp_result_t      owed_results[$];

    int               error_count;
    int               cycle_count;
    int               req_idle_pct;
    int               rsp_stall_pct;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Table model: resolve one accepted item and update the local table
    // the same way the block must. Lowest matching slot wins; a learn that
    // matches nothing appends, or is dropped when every slot is used.
    // ------------------------------------------------------------------
    function automatic arp_result_t resolve_request(
        input logic [arpc_pkg::OP_W-1:0]  op,
        input logic [arpc_pkg::IP_W-1:0]  ip,
        input logic [arpc_pkg::MAC_W-1:0] mac);
        arp_result_t res;
        int          hit_idx;
        int          k;
        res.status  = arpc_pkg::STS_MISS;
        res.mac_out = '0;
        res.slot    = '0;
        hit_idx     = -1;
        for (k = 0; k < fill_count; k++)
        begin
            if (hit_idx < 0 && ip_table[k] == ip)
                hit_idx = k;
        end
        if (op == arpc_pkg::OP_LOOKUP)
        begin
            // a miss keeps status MISS with zero mac and slot
            if (hit_idx >= 0)
            begin
                res.status  = arpc_pkg::STS_HIT;
                res.mac_out = mac_table[hit_idx];
                res.slot    = arpc_pkg::SLOT_W'(hit_idx);
            end
        end
        else if (hit_idx >= 0)
        begin
            mac_table[hit_idx] = mac;
            res.status         = arpc_pkg::STS_UPDATED;
            res.slot           = arpc_pkg::SLOT_W'(hit_idx);
        end
        else if (fill_count < arpc_pkg::TABLE_ENTRIES)
        begin
            ip_table[fill_count]  = ip;
            mac_table[fill_count] = mac;
            res.status            = arpc_pkg::STS_INSERTED;
            res.slot              = arpc_pkg::SLOT_W'(fill_count);
            fill_count++;
        end
        else
        begin
            // table full: nothing stored, mac and slot stay zero
            res.status = arpc_pkg::STS_FULL;
        end
        return res;
    endfunction

    function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
        return arpc_pkg::MAC_W'({$urandom(), $urandom()});
    endfunction

    // ------------------------------------------------------------------
    // Sender: entered and left on a falling edge. Idle at random first,
    // then hold the item until it is accepted, and record its result.
    // valid stays high into the next item, so it is never dropped and
    // raised again within one time step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [arpc_pkg::OP_W-1:0]  op,
                             input logic [arpc_pkg::IP_W-1:0]  ip,
                             input logic [arpc_pkg::MAC_W-1:0] mac);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.op      <= op;
        req_bus.ip_addr <= ip;
        req_bus.mac_in  <= mac;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        owed_results.push_back(resolve_request(op, ip, mac));
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // One random item. new_pct sets how often a fresh address is learned,
    // which controls how fast the table fills. The rest is mostly traffic
    // on known addresses (hits, updates, near misses) plus some noise.
    // ------------------------------------------------------------------
    task automatic send_random_item(input int new_pct);
        int                         pick;
        logic [arpc_pkg::IP_W-1:0]  known_ip;
        pick     = $urandom_range(0, 99);
        known_ip = (fill_count > 0) ? ip_table[$urandom_range(0, fill_count - 1)] : '0;
        if (pick < new_pct)
            send_item(arpc_pkg::OP_LEARN, $urandom(), rand_mac());
        else if (fill_count > 0 && pick < new_pct + 30)
            send_item(arpc_pkg::OP_LOOKUP, known_ip, rand_mac());
        else if (fill_count > 0 && pick < new_pct + 50)
            send_item(arpc_pkg::OP_LEARN, known_ip, rand_mac());
        else if (fill_count > 0 && pick < new_pct + 60)
            // one address bit off a stored entry: must not match
            send_item(arpc_pkg::OP_LOOKUP,
                      known_ip ^ (arpc_pkg::IP_W'(1) << $urandom_range(0, arpc_pkg::IP_W - 1)),
                      rand_mac());
        else if (pick < new_pct + 66)
        begin
            // noise: either op on the corner addresses
            case ($urandom_range(0, 2))
                0:       known_ip = '0;
                1:       known_ip = arpc_pkg::IP_W'(1);
                default: known_ip = '1;
            endcase
            send_item(arpc_pkg::OP_W'($urandom_range(0, 1)), known_ip, rand_mac());
        end
        else
            send_item(arpc_pkg::OP_LOOKUP, $urandom(), rand_mac());
    endtask

    // ------------------------------------------------------------------
    // Test: corner addresses and MACs, every status except full, near
    // misses, and lookups whose mac_in must be ignored.
    // ------------------------------------------------------------------
    task automatic test_directed_edges();
        send_item(arpc_pkg::OP_LOOKUP, '0, '0);
        send_item(arpc_pkg::OP_LOOKUP, '1, '1);
        send_item(arpc_pkg::OP_LEARN,  '0, '0);
        send_item(arpc_pkg::OP_LEARN,  '1, '1);
        send_item(arpc_pkg::OP_LOOKUP, '0, '1);
        send_item(arpc_pkg::OP_LOOKUP, '1, '0);
        send_item(arpc_pkg::OP_LEARN,  '0, 48'hAAAA_AAAA_AAAA);
        send_item(arpc_pkg::OP_LOOKUP, '0, 48'h5555_5555_5555);
        send_item(arpc_pkg::OP_LOOKUP, 32'h0000_0001, '0);
        send_item(arpc_pkg::OP_LOOKUP, 32'h7FFF_FFFF, '0);
        send_item(arpc_pkg::OP_LEARN,  '1, '0);
        send_item(arpc_pkg::OP_LOOKUP, '1, '1);
        send_item(arpc_pkg::OP_LEARN,  32'h8000_0000, 48'h8000_0000_0000);
        send_item(arpc_pkg::OP_LOOKUP, 32'h8000_0000, '0);
        send_item(arpc_pkg::OP_LEARN,  32'hC0A8_0001, 48'h0123_4567_89AB);
        send_item(arpc_pkg::OP_LEARN,  32'hC0A8_0001, 48'hFEDC_BA98_7654);
        send_item(arpc_pkg::OP_LOOKUP, 32'hC0A8_0001, '0);
        send_item(arpc_pkg::OP_LOOKUP, 32'hC0A8_0000, '0);
    endtask

    // Test: mixed traffic on a lightly filled table.
    task automatic test_sparse_table();
        repeat (200) send_random_item(10);
    endtask

    // Test: learn fast enough to fill every slot and run into drops.
    task automatic test_filling_table();
        repeat (220) send_random_item(30);
    endtask

    // Test: full table, back to back, no idling on either side.
    task automatic test_full_table();
        repeat (230) send_random_item(20);
    endtask

    // ------------------------------------------------------------------
    // Receiver: pick ready at each falling edge from the stall rate.
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_bus.ready <= rst_n && ($urandom_range(0, 99) >= rsp_stall_pct);

    // ------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        arp_result_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result with nothing owed: status %0d mac_out %h slot %0d",
                       rsp_bus.status, rsp_bus.mac_out, rsp_bus.slot);
                error_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                    error_count++;
                end
                if (rsp_bus.mac_out !== want.mac_out)
                begin
                    $error("mac_out: expected %h, got %h", want.mac_out, rsp_bus.mac_out);
                    error_count++;
                end
                if (rsp_bus.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp_bus.slot);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if it hangs.
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        error_count     = 0;
        fill_count      = 0;
        req_idle_pct    = 17;
        rsp_stall_pct   = 68;
        rst_n           = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.op      = arpc_pkg::OP_LOOKUP;
        req_bus.ip_addr = '0;
        req_bus.mac_in  = '0;

        // hold reset, release on a falling edge
        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender idles a little, receiver stalls a lot
        test_directed_edges();
        test_sparse_table();
        wait_drained();

        // swap the pressure
        req_idle_pct  = 68;
        rsp_stall_pct = 17;
        test_filling_table();
        wait_drained();

        // full rate both ways
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        test_full_table();
        wait_drained();

        // catch any stray result after the last one owed
        repeat (DRAIN_TICKS) @(posedge clk);

        if (error_count == 0 && owed_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
